// ===== design/tess_pkg.sv =====
// Shared types and constants of the timed and event slot scheduler.
`default_nettype none
package tess_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS);

	typedef enum logic [2:0] {
		OP_TICK         = 3'd0,
		OP_POLL         = 3'd1,
		OP_QUEUE_ONCE   = 3'd2,
		OP_QUEUE_PERIOD = 3'd3,
		OP_QUEUE_EVENT  = 3'd4,
		OP_STOP         = 3'd5,
		OP_DISPATCH     = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_ACK   = 2'd0,
		ST_FIRED = 2'd1,
		ST_FULL  = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_EVAL,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [31:0] deadline;
		logic [15:0] period;
		logic [6:0]  evt;
		logic [7:0]  tag;
	} slot_rec_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  slot;
		logic [7:0]  tag;
		logic        last;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic clr_scan;
		logic step;
		logic single;
		logic take;
		logic flush;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic hit;
		logic at_end;
		logic cnt_last;
		logic held_v;
		logic out_free;
	} ctrl_stat_t;

endpackage
`default_nettype wire

// ===== design/tess_cmd_if.sv =====
// Input command channel of the scheduler.
`default_nettype none
interface tess_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [15:0] delay_ms;
	logic [6:0]  event_id;
	logic [7:0]  handle;
	logic [7:0]  callback_tag;

	modport source (
		output valid, opcode, delay_ms, event_id, handle, callback_tag,
		input  ready
	);
	modport sink (
		input  valid, opcode, delay_ms, event_id, handle, callback_tag,
		output ready
	);
endinterface
`default_nettype wire

// ===== design/tess_res_if.sv =====
// Result channel of the scheduler.
`default_nettype none
interface tess_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] slot;
	logic [7:0] fired_tag;
	logic       last;

	modport source (
		output valid, status, slot, fired_tag, last,
		input  ready
	);
	modport sink (
		input  valid, status, slot, fired_tag, last,
		output ready
	);
endinterface
`default_nettype wire

// ===== design/tess_ctrl.sv =====
// Controller state machine that sequences commands and slot scans.
`default_nettype none
module tess_ctrl
	import tess_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   is_queue, is_scan, fire_ok, scan_done;

	assign is_queue  = stat.op inside {OP_QUEUE_ONCE, OP_QUEUE_PERIOD, OP_QUEUE_EVENT};
	assign is_scan   = is_queue || stat.op inside {OP_POLL, OP_DISPATCH};
	// A firing displaces the held result into the output register, so that must be free.
	assign fire_ok   = !stat.held_v || stat.out_free;
	assign scan_done = stat.at_end || stat.cnt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (is_scan) state_d = S_READ;
				else if (stat.out_free) state_d = S_IDLE;
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (is_queue) begin
					if (stat.hit) begin
						if (stat.out_free) state_d = S_IDLE;
					end else begin
						state_d = stat.at_end ? S_FLUSH : S_READ;
					end
				end else if (stat.hit) begin
					if (fire_ok) state_d = scan_done ? S_FLUSH : S_READ;
				end else begin
					state_d = stat.at_end ? S_FLUSH : S_READ;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in  = 1'b1;
					cmd.clr_scan = 1'b1;
				end
			end
			S_DECODE: begin
				if (!is_scan && stat.out_free) cmd.single = 1'b1;
			end
			S_READ: begin
			end
			S_EVAL: begin
				if (is_queue) begin
					if (stat.hit) cmd.take = stat.out_free;
					else cmd.step = !stat.at_end;
				end else if (stat.hit) begin
					cmd.take = fire_ok;
					cmd.step = fire_ok && !scan_done;
				end else begin
					cmd.step = !stat.at_end;
				end
			end
			S_FLUSH: begin
				cmd.flush = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/tess_dp.sv =====
// Datapath: slot table, time counter, scan index, held result and output register.
`default_nettype none
module tess_dp
	import tess_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_ready,
	input  ctrl_cmd_t  cmd,
	output ctrl_stat_t stat,
	tess_cmd_if.sink   cmd_ch,
	tess_res_if.source res_ch
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	op_t                op_q;
	logic [15:0]        delay_q;
	logic [6:0]         ev_q;
	logic [7:0]         handle_q;
	logic [7:0]         tag_q;

	logic [31:0]        time_q;
	logic [SLOT_COUNT-1:0] busy_q;
	logic [SLOT_COUNT-1:0] is_ev_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               held_v_q;
	result_t            held_q;
	logic               out_v_q;
	result_t            out_q;

	slot_rec_t          rec_mem_q [SLOT_COUNT];
	slot_rec_t          rd_q;

	logic               is_queue, handle_ok, out_free, hit;
	logic               push, mem_we;
	result_t            push_res;
	slot_rec_t          mem_wd;
	logic [SLOT_W-1:0]  hidx;

	assign is_queue  = op_q inside {OP_QUEUE_ONCE, OP_QUEUE_PERIOD, OP_QUEUE_EVENT};
	assign handle_ok = handle_q < 8'(SLOT_COUNT);
	assign hidx      = handle_q[SLOT_W-1:0];
	assign out_free  = !out_v_q || res_ch.ready;

	always_comb begin
		case (op_q)
			OP_POLL:
				hit = busy_q[idx_q] && !is_ev_q[idx_q] && (rd_q.deadline <= time_q);
			OP_DISPATCH:
				hit = busy_q[idx_q] && is_ev_q[idx_q] && (rd_q.evt == ev_q);
			OP_QUEUE_ONCE, OP_QUEUE_PERIOD, OP_QUEUE_EVENT:
				hit = !busy_q[idx_q];
			default:
				hit = 1'b0;
		endcase
	end

	assign stat.op       = op_q;
	assign stat.hit      = hit;
	assign stat.at_end   = idx_q == SLOT_W'(SLOT_COUNT - 1);
	assign stat.cnt_last = cnt_q == CNT_W'(MAX_RESULTS - 1);
	assign stat.held_v   = held_v_q;
	assign stat.out_free = out_free;

	// Result beat and table write for the current command.
	always_comb begin
		push     = 1'b0;
		push_res = '{status: ST_ACK, slot: 4'd0, tag: 8'd0, last: 1'b1};
		mem_we   = 1'b0;
		mem_wd   = rd_q;
		if (cmd.single) begin
			push = 1'b1;
			if (op_q == OP_STOP) begin
				if (handle_ok) push_res.slot = handle_q[3:0];
				else push_res.status = ST_BAD;
			end
		end
		if (cmd.take) begin
			if (is_queue) begin
				push            = 1'b1;
				push_res.slot   = 4'(idx_q);
				mem_we          = 1'b1;
				mem_wd.deadline = (op_q == OP_QUEUE_EVENT) ? 32'd0 : time_q + 32'(delay_q);
				mem_wd.period   = (op_q == OP_QUEUE_PERIOD) ? delay_q : 16'd0;
				mem_wd.evt      = (op_q == OP_QUEUE_EVENT) ? ev_q : 7'd0;
				mem_wd.tag      = tag_q;
			end else begin
				push          = held_v_q;
				push_res      = held_q;
				push_res.last = 1'b0;
				if (op_q == OP_POLL && rd_q.period != 16'd0) begin
					mem_we          = 1'b1;
					mem_wd.deadline = time_q + 32'(rd_q.period);
				end
			end
		end
		if (cmd.flush) begin
			push = 1'b1;
			if (is_queue) begin
				push_res.status = ST_FULL;
			end else if (held_v_q) begin
				push_res      = held_q;
				push_res.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			busy_q   <= '0;
			is_ev_q  <= '0;
			idx_q    <= '0;
			cnt_q    <= '0;
			held_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.clr_scan) begin
				idx_q    <= '0;
				cnt_q    <= '0;
				held_v_q <= 1'b0;
			end
			if (cmd.step) idx_q <= idx_q + 1'b1;
			if (cmd.single) begin
				if (op_q == OP_TICK) time_q <= time_q + 32'd1;
				if (op_q == OP_STOP && handle_ok) begin
					busy_q[hidx]  <= 1'b0;
					is_ev_q[hidx] <= 1'b0;
				end
			end
			if (cmd.take) begin
				if (is_queue) begin
					busy_q[idx_q]  <= 1'b1;
					is_ev_q[idx_q] <= op_q == OP_QUEUE_EVENT;
				end else begin
					cnt_q    <= cnt_q + 1'b1;
					held_v_q <= 1'b1;
					if (op_q == OP_DISPATCH) begin
						busy_q[idx_q]  <= 1'b0;
						is_ev_q[idx_q] <= 1'b0;
					end else if (rd_q.period == 16'd0) begin
						busy_q[idx_q] <= 1'b0;
					end
				end
			end
			if (push) out_v_q <= 1'b1;
			else if (res_ch.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= op_t'(cmd_ch.opcode);
			delay_q  <= cmd_ch.delay_ms;
			ev_q     <= cmd_ch.event_id;
			handle_q <= cmd_ch.handle;
			tag_q    <= cmd_ch.callback_tag;
		end
		if (cmd.take && !is_queue) begin
			held_q <= '{status: ST_FIRED, slot: 4'(idx_q), tag: rd_q.tag, last: 1'b0};
		end
		if (push) out_q <= push_res;
	end

	// Slot table: one write port, one registered read port at the scan index.
	always_ff @(posedge clk) begin
		if (mem_we) rec_mem_q[idx_q] <= mem_wd;
		rd_q <= rec_mem_q[idx_q];
	end

	assign cmd_ch.ready     = in_ready;
	assign res_ch.valid     = out_v_q;
	assign res_ch.status    = out_q.status;
	assign res_ch.slot      = out_q.slot;
	assign res_ch.fired_tag = out_q.tag;
	assign res_ch.last      = out_q.last;

endmodule
`default_nettype wire

// ===== design/timed_and_event_slot_scheduler.sv =====
// Top level of the timed and event slot scheduler.
//
// Commands enter on the cmd channel (valid/ready); each accepted beat yields
// one or more result beats on the res channel, the final one flagged by last.
// A new command is taken only when the previous one has finished its work;
// the registered result output lets the next command in while its beat waits.
// Tick, stop and unknown opcodes register their result in the decode
// state once the output register is free. Poll, dispatch and queue walk
// the slot table slot by slot, a table read and then an evaluate step per
// slot, set by the single read port of the table; a queue request stops at
// the first free slot. Poll and dispatch report at most 16 firings per
// command; the rest stay pending for a later command. Reset clears the
// time, all busy and event flags and the result valid flag; the slot table
// needs no clearing, since its contents count only for busy slots.
// When the receiver stalls, the scan waits on the next firing that has to
// leave, and the cmd channel stays closed until the command completes.
`default_nettype none
module timed_and_event_slot_scheduler
	import tess_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	tess_cmd_if.sink   cmd,
	tess_res_if.source res
);

	ctrl_cmd_t  ctl_cmd;
	ctrl_stat_t ctl_stat;
	logic       in_ready;

	tess_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.stat     (ctl_stat),
		.cmd      (ctl_cmd)
	);

	tess_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ready (in_ready),
		.cmd      (ctl_cmd),
		.stat     (ctl_stat),
		.cmd_ch   (cmd),
		.res_ch   (res)
	);

endmodule
`default_nettype wire
